// ----- sv/abcm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abcm_pkg
// Shared types, tables and GF(2^8) helpers for the block cipher core.
// ----------------------------------------------------------------------------
package abcm_pkg;

    typedef logic [7:0] byte_tbl_t [256];

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXPAND = 5'b00010,
        ST_LOAD   = 5'b00100,
        ST_RUN    = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    localparam logic [1:0] MODE_ECB = 2'd0;
    localparam logic [1:0] MODE_CBC = 2'd1;
    localparam logic [1:0] MODE_CFB = 2'd2;
    localparam logic [1:0] MODE_OFB = 2'd3;

    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_192 = 2'd1;

    localparam logic [3:0] CFG_KEY_SIZE   = 4'd0;
    localparam logic [3:0] CFG_CHAIN_MODE = 4'd1;
    localparam logic [3:0] CFG_KEY_WORD_0 = 4'd2;
    localparam logic [3:0] CFG_KEY_WORD_1 = 4'd3;
    localparam logic [3:0] CFG_KEY_WORD_2 = 4'd4;
    localparam logic [3:0] CFG_KEY_WORD_3 = 4'd5;
    localparam logic [3:0] CFG_IV_HIGH    = 4'd6;
    localparam logic [3:0] CFG_IV_LOW     = 4'd7;

    localparam int RK_DEPTH = 16;
    localparam int BLK_W    = 128;

    localparam byte_tbl_t SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic byte_tbl_t build_sbox_rev();
        byte_tbl_t t;
        for (int i = 0; i < 256; i++) begin
            t[SBOX[i]] = 8'(i);
        end
        return t;
    endfunction

    localparam byte_tbl_t SBOX_REV = build_sbox_rev();

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] col);
        logic [7:0] a0, a1, a2, a3;
        a0 = col[31:24];
        a1 = col[23:16];
        a2 = col[15:8];
        a3 = col[7:0];
        return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    function automatic logic [7:0] gm9(input logic [7:0] a);
        return xt(xt(xt(a))) ^ a;
    endfunction

    function automatic logic [7:0] gm11(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(a) ^ a;
    endfunction

    function automatic logic [7:0] gm13(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
    endfunction

    function automatic logic [7:0] gm14(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
        logic [7:0] a0, a1, a2, a3;
        a0 = col[31:24];
        a1 = col[23:16];
        a2 = col[15:8];
        a3 = col[7:0];
        return {gm14(a0) ^ gm11(a1) ^ gm13(a2) ^ gm9(a3),
                gm9(a0) ^ gm14(a1) ^ gm11(a2) ^ gm13(a3),
                gm13(a0) ^ gm9(a1) ^ gm14(a2) ^ gm11(a3),
                gm11(a0) ^ gm13(a1) ^ gm9(a2) ^ gm14(a3)};
    endfunction

endpackage

// ----- sv/abcm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abcm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module abcm_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/aes_block_cipher_modes_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_block_cipher_modes_core
// AES-128/192/256 with ECB, CBC, CFB and OFB chaining; round keys in a RAM.
// ----------------------------------------------------------------------------
// An accepted word passes through the LOAD, RUN and FINISH states to its result,
// one round per cycle in RUN against a round key read from the key RAM in the
// cycle before. After a key or key size write, the next word first expands the
// key into the RAM in the EXPAND state. One word at a time; a new word is taken
// while the result still waits. Reset clears the control, configuration and
// chaining registers; the data path registers are not reset.
module aes_block_cipher_modes_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic        first_block,
    input  logic [63:0] data_high,
    input  logic [63:0] data_low,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_high,
    output logic [63:0] result_low
);
    import abcm_pkg::*;

    localparam int AW = $clog2(RK_DEPTH);

    state_t         state_reg, state_next;
    logic [1:0]     key_size_reg, chain_mode_reg;
    logic [255:0]   key_reg;
    logic [127:0]   iv_reg, chain_reg;
    logic           keys_valid_reg;
    logic [127:0]   blk_reg, din_reg, cprev_reg;
    logic           dec_reg;
    logic           cmd_reg;
    logic [1:0]     mode_reg;
    logic [3:0]     cnt_reg;
    logic [AW-1:0]  kcnt_reg;
    logic [3:0]     pos_reg;
    logic [7:0]     rc_reg;
    logic [7:0][31:0] hist_reg;
    logic           out_valid_reg;
    logic [127:0]   out_reg;

    logic [3:0]     nk, nr;
    logic           accept, cfg_we;
    logic [127:0]   cstart, blk_init;

    // key expansion
    logic [31:0]    key_words [8];
    logic [3:0][31:0] grp;
    logic [127:0]   grp_vec;
    logic           any_g;
    logic [3:0]     pos_step;

    // rounds
    logic           ram_we;
    logic [AW-1:0]  ram_raddr;
    logic [127:0]   rk;
    logic [127:0]   enc_sub, enc_mix, dec_sub, dec_key, dec_mix, round_next;
    logic           last_round;

    logic [127:0]   res, chain_new;
    logic           finish_go;

    assign nk = (key_size_reg == KEY_128) ? 4'd4 : ((key_size_reg == KEY_192) ? 4'd6 : 4'd8);
    assign nr = nk + 4'd6;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid & in_ready;
    assign out_valid = out_valid_reg;
    assign result_high = out_reg[127:64];
    assign result_low  = out_reg[63:0];

    assign cstart = first_block ? iv_reg : chain_reg;

    always_comb
    begin
        case (chain_mode_reg)
            MODE_ECB: blk_init = {data_high, data_low};
            MODE_CBC: blk_init = cmd ? {data_high, data_low} : ({data_high, data_low} ^ cstart);
            default:  blk_init = cstart;
        endcase
    end

    always_comb
    begin
        logic [31:0] prev, t, base;
        logic [5:0]  idx;
        logic [3:0]  p;
        logic [2:0]  hidx;
        for (int i = 0; i < 8; i++)
        begin
            key_words[i] = key_reg[255-32*i -: 32];
        end
        prev  = hist_reg[7];
        any_g = 1'b0;
        for (int j = 0; j < 4; j++)
        begin
            idx  = {kcnt_reg, 2'b00} + 6'(j);
            p    = pos_reg + 4'(j);
            if (p >= nk)
            begin
                p = p - nk;
            end
            hidx = 3'(4'(8 + j) - nk);
            base = hist_reg[hidx];
            t    = prev;
            if (p == 4'd0)
            begin
                t = sub_word({prev[23:0], prev[31:24]}) ^ {rc_reg, 24'h0};
                if (idx >= {2'b00, nk})
                begin
                    any_g = 1'b1;
                end
            end
            else if (nk == 4'd8 && p == 4'd4)
            begin
                t = sub_word(prev);
            end
            if (idx < {2'b00, nk})
            begin
                grp[j] = key_words[idx[2:0]];
            end
            else
            begin
                grp[j] = base ^ t;
            end
            prev = grp[j];
        end
        grp_vec  = {grp[0], grp[1], grp[2], grp[3]};
        pos_step = pos_reg + 4'd4;
        if (pos_step >= nk)
        begin
            pos_step = pos_step - nk;
        end
    end

    assign ram_we = (state_reg == ST_EXPAND);

    always_comb
    begin
        if (state_reg == ST_LOAD)
        begin
            ram_raddr = dec_reg ? AW'(nr) : '0;
        end
        else
        begin
            ram_raddr = dec_reg ? AW'(nr - cnt_reg - 4'd1) : AW'(cnt_reg + 4'd1);
        end
    end

    abcm_ram #(
        .WIDTH(BLK_W),
        .DEPTH(RK_DEPTH)
    ) u_rk_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(kcnt_reg),
        .wdata(grp_vec),
        .raddr(ram_raddr),
        .rdata(rk)
    );

    assign last_round = (cnt_reg == nr);

    always_comb
    begin
        logic [7:0] sb [16];
        logic [7:0] et [16];
        logic [7:0] dt [16];
        for (int k = 0; k < 16; k++)
        begin
            sb[k] = blk_reg[127-8*k -: 8];
        end
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                et[r+4*c]             = SBOX[sb[r+4*((c+r)&3)]];
                dt[r+4*((c+r)&3)]     = SBOX_REV[sb[r+4*c]];
            end
        end
        for (int k = 0; k < 16; k++)
        begin
            enc_sub[127-8*k -: 8] = et[k];
            dec_sub[127-8*k -: 8] = dt[k];
        end
        dec_key = dec_sub ^ rk;
        for (int c = 0; c < 4; c++)
        begin
            enc_mix[127-32*c -: 32] = mix_col(enc_sub[127-32*c -: 32]);
            dec_mix[127-32*c -: 32] = inv_mix_col(dec_key[127-32*c -: 32]);
        end
        if (cnt_reg == 4'd0)
        begin
            round_next = blk_reg ^ rk;
        end
        else if (dec_reg)
        begin
            round_next = last_round ? dec_key : dec_mix;
        end
        else
        begin
            round_next = (last_round ? enc_sub : enc_mix) ^ rk;
        end
    end

    always_comb
    begin
        case (mode_reg)
            MODE_ECB:
            begin
                res       = blk_reg;
                chain_new = cprev_reg;
            end
            MODE_CBC:
            begin
                res       = dec_reg ? (blk_reg ^ cprev_reg) : blk_reg;
                chain_new = dec_reg ? din_reg : blk_reg;
            end
            MODE_CFB:
            begin
                res       = din_reg ^ blk_reg;
                chain_new = cmd_reg ? din_reg : (din_reg ^ blk_reg);
            end
            default:
            begin
                res       = din_reg ^ blk_reg;
                chain_new = blk_reg;
            end
        endcase
    end

    assign finish_go = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = keys_valid_reg ? ST_LOAD : ST_EXPAND;
            ST_EXPAND: if (AW'(nr) == kcnt_reg) state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_RUN;
            ST_RUN:    if (last_round) state_next = ST_FINISH;
            ST_FINISH: if (finish_go) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            key_size_reg   <= '0;
            chain_mode_reg <= '0;
            key_reg        <= '0;
            iv_reg         <= '0;
            chain_reg      <= '0;
            keys_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            dec_reg        <= 1'b0;
            cmd_reg        <= 1'b0;
            mode_reg       <= '0;
            cnt_reg        <= '0;
            kcnt_reg       <= '0;
            pos_reg        <= '0;
            rc_reg         <= 8'h01;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY_SIZE:   key_size_reg   <= cfg_data[1:0];
                    CFG_CHAIN_MODE: chain_mode_reg <= cfg_data[1:0];
                    CFG_KEY_WORD_0: key_reg[255:192] <= cfg_data;
                    CFG_KEY_WORD_1: key_reg[191:128] <= cfg_data;
                    CFG_KEY_WORD_2: key_reg[127:64]  <= cfg_data;
                    CFG_KEY_WORD_3: key_reg[63:0]    <= cfg_data;
                    CFG_IV_HIGH:    iv_reg[127:64]   <= cfg_data;
                    CFG_IV_LOW:     iv_reg[63:0]     <= cfg_data;
                    default: ;
                endcase
                if (cfg_index == CFG_KEY_SIZE || cfg_index == CFG_KEY_WORD_0 ||
                    cfg_index == CFG_KEY_WORD_1 || cfg_index == CFG_KEY_WORD_2 ||
                    cfg_index == CFG_KEY_WORD_3)
                begin
                    keys_valid_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                dec_reg  <= cmd && (chain_mode_reg == MODE_ECB || chain_mode_reg == MODE_CBC);
                cmd_reg  <= cmd;
                mode_reg <= chain_mode_reg;
                kcnt_reg <= '0;
                pos_reg  <= '0;
                rc_reg   <= 8'h01;
            end
            if (state_reg == ST_EXPAND)
            begin
                kcnt_reg <= kcnt_reg + 1'b1;
                pos_reg  <= pos_step;
                if (any_g)
                begin
                    rc_reg <= xt(rc_reg);
                end
                if (AW'(nr) == kcnt_reg)
                begin
                    keys_valid_reg <= 1'b1;
                end
            end
            if (state_reg == ST_LOAD)
            begin
                cnt_reg <= '0;
            end
            if (state_reg == ST_RUN)
            begin
                cnt_reg <= cnt_reg + 4'd1;
            end
            if (finish_go)
            begin
                chain_reg     <= chain_new;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            blk_reg   <= blk_init;
            din_reg   <= {data_high, data_low};
            cprev_reg <= cstart;
        end
        if (state_reg == ST_EXPAND)
        begin
            hist_reg <= {grp[3], grp[2], grp[1], grp[0], hist_reg[7:4]};
        end
        if (state_reg == ST_RUN)
        begin
            blk_reg <= round_next;
        end
        if (finish_go)
        begin
            out_reg <= res;
        end
    end

    a_expand_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXPAND |-> !keys_valid_reg)
        else $error("key expansion runs over a valid schedule");

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXPAND || state_reg == ST_LOAD))
        else $error("accepted word did not start processing");

    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> cnt_reg <= nr)
        else $error("round counter past last round");

endmodule
